// ===== src/sbp_pkg.sv =====
// ----------------------------------------------------------------------------
// sbp_pkg - shared types and constants for the sample byte packer
// Holds the packer state, result slot types and fixed codes used by the
// packing logic and the top level.
// ----------------------------------------------------------------------------
package sbp_pkg;

    localparam int CARRY_W    = 7;
    localparam int COUNT_W    = 3;
    localparam int BSS_W      = 16;
    localparam int SLOT_COUNT = 3;

    // command codes
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_START  = 1'b1;

    // configuration register indexes
    localparam logic CFG_SYNC_BYTE   = 1'b0;
    localparam logic CFG_SYNC_PERIOD = 1'b1;

    localparam logic [7:0]  SYNC_BYTE_RESET   = 8'hFF;
    localparam logic [15:0] SYNC_PERIOD_RESET = 16'd64;

    // escape masks: top bit of a byte, and the mask for the lowest bit (8 - 1)
    localparam logic [7:0] TOP_BIT       = 8'h80;
    localparam int         FULL_BYTE_LSB = 8 - 1;
    localparam logic [7:0] LSB_MASK      = TOP_BIT >> FULL_BYTE_LSB;

    typedef struct packed {
        logic [CARRY_W-1:0] carry_bits;
        logic [COUNT_W-1:0] carry_count;
        logic [BSS_W-1:0]   bytes_since_sync;
    } t_state;

    typedef struct packed {
        logic [7:0] data;
        logic       is_sync;
    } t_slot;

    // all results caused by one input transfer
    typedef struct packed {
        t_slot [SLOT_COUNT-1:0] slot;
        logic  [1:0]            count;
    } t_batch;

endpackage

// ===== src/sbp_pack.sv =====
// ----------------------------------------------------------------------------
// sbp_pack - single-pass packing logic
// Splits carried bits plus one sample into bytes, escapes sync look-alikes,
// decides on a trailing sync byte and computes the next packer state.
// ----------------------------------------------------------------------------
module sbp_pack #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_command,
    input  logic [SAMPLE_BITS-1:0] i_sample_value,
    input  logic [7:0]             i_sync_byte,
    input  logic [15:0]            i_sync_period,
    input  sbp_pkg::t_state        i_state,
    output sbp_pkg::t_state        o_state,
    output sbp_pkg::t_batch        o_batch
);
    import sbp_pkg::*;

    localparam int ACC_W = SAMPLE_BITS + CARRY_W;
    localparam int TOT_W = $clog2(SAMPLE_BITS + 8);

    logic [CARRY_W-1:0] kept;
    logic [ACC_W-1:0]   acc;
    logic [TOT_W-1:0]   total;
    logic [TOT_W-1:0]   sh0;
    logic [TOT_W-1:0]   sh1;
    logic [1:0]         nbytes;
    logic [2:0]         rem;
    logic [7:0]         byte0;
    logic [7:0]         byte1;
    logic [7:0]         flip0;
    logic [7:0]         d0;
    logic [7:0]         d1;
    logic [BSS_W:0]     sum;
    logic [BSS_W-1:0]   bss_new;
    logic [BSS_W-1:0]   period_eff;
    logic               sync_hit;
    t_slot              sync_slot;

    assign kept  = i_state.carry_bits & ~({CARRY_W{1'b1}} << i_state.carry_count);
    assign acc   = {kept, i_sample_value};
    assign total = TOT_W'(i_state.carry_count) + TOT_W'(SAMPLE_BITS);
    assign sh0   = total - TOT_W'(8);
    assign sh1   = sh0 - TOT_W'(8);
    assign nbytes = 2'(total >> 3);
    assign rem    = total[2:0];

    assign byte0 = 8'(acc >> sh0);
    assign byte1 = 8'(acc >> sh1);

    // first byte starting with k carried bits flips bit 7-k, others bit 0
    assign flip0 = (i_state.carry_count != '0) ? (TOP_BIT >> i_state.carry_count)
                                               : LSB_MASK;
    assign d0 = (byte0 == i_sync_byte) ? (byte0 ^ flip0) : byte0;
    assign d1 = (byte1 == i_sync_byte) ? (byte1 ^ LSB_MASK) : byte1;

    // saturating byte count
    assign sum        = {1'b0, i_state.bytes_since_sync} + (BSS_W+1)'(nbytes);
    assign bss_new    = sum[BSS_W] ? {BSS_W{1'b1}} : sum[BSS_W-1:0];
    assign period_eff = (i_sync_period == '0) ? BSS_W'(1) : i_sync_period;
    assign sync_hit   = (rem == 3'd0) &&
                        (({1'b0, bss_new} + (BSS_W+1)'(1)) >= {1'b0, period_eff});

    assign sync_slot.data    = i_sync_byte;
    assign sync_slot.is_sync = 1'b1;

    always_comb begin
        o_batch.slot[0]         = '{data: d0, is_sync: 1'b0};
        o_batch.slot[1]         = '{data: d1, is_sync: 1'b0};
        o_batch.slot[2]         = sync_slot;
        o_batch.count           = nbytes + 2'(sync_hit);
        o_state.carry_count     = rem;
        o_state.carry_bits      = CARRY_W'(acc) & ~({CARRY_W{1'b1}} << rem);
        o_state.bytes_since_sync = sync_hit ? '0 : bss_new;
        if (nbytes == 2'd1) begin
            o_batch.slot[1] = sync_slot;
        end
        if (i_command == CMD_START) begin
            o_batch.slot[0] = sync_slot;
            o_batch.count   = 2'd1;
            o_state         = '0;
        end
    end

endmodule

// ===== src/sample_byte_packer_sync.sv =====
// ----------------------------------------------------------------------------
// sample_byte_packer_sync - sample to byte stream packer with sync insertion
// Packs fixed-width samples MSB first into bytes and inserts sync markers.
//   Input channel (i_in_valid / o_in_stall) carries a command and a sample.
//   Command encode appends the sample to the carried bits; every full byte
//   is sent, sync look-alikes get one bit inverted, and a sync byte follows
//   when the sample ends on a byte boundary and the period is reached.
//   Command start sends one sync byte and drops carried bits.
//   Output channel (o_out_valid / i_out_stall) moves one byte per transfer,
//   with o_is_sync on markers and o_last on the final byte of an input.
//   Results are registered and appear in the cycle after the input transfer.
//   Throughput: an input transfer yields 0 to 3 bytes, and the output drains
//   one byte per cycle while i_out_stall is low, over a single byte lane.
//   A new input is taken in the same cycle the last byte of the previous
//   one leaves.
//   Reset clears carried bits, the byte count and the result queue, and
//   loads the sync byte 0xFF and period 64. A stalled receiver holds the
//   current byte; the input stalls once the queue cannot be emptied.
//   Configuration writes are to be made only while the block is idle.
// ----------------------------------------------------------------------------
module sample_byte_packer_sync #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [15:0]            i_cfg_data,
    // input channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_command,
    input  logic [SAMPLE_BITS-1:0] i_sample_value,
    // output channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [7:0]             o_out_byte,
    output logic                   o_is_sync,
    output logic                   o_last
);
    import sbp_pkg::*;

    logic [7:0]  r_sync_byte;
    logic [15:0] r_sync_period;
    t_state      r_state;
    t_state      n_state;
    t_batch      batch;

    // result queue: slot 0 is the head, shifted down on each output transfer
    t_slot [SLOT_COUNT-1:0] r_slot;
    t_slot [SLOT_COUNT-1:0] n_slot;
    logic  [1:0]            r_count;
    logic  [1:0]            n_count;

    logic in_xfer;
    logic out_xfer;

    sbp_pack #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_pack (
        .i_command     (i_command),
        .i_sample_value(i_sample_value),
        .i_sync_byte   (r_sync_byte),
        .i_sync_period (r_sync_period),
        .i_state       (r_state),
        .o_state       (n_state),
        .o_batch       (batch)
    );

    assign o_out_valid = (r_count != 2'd0);
    assign out_xfer    = o_out_valid && !i_out_stall;
    // accept when the queue is empty or its last byte leaves this cycle
    assign o_in_stall  = (r_count > 2'd1) || ((r_count == 2'd1) && i_out_stall);
    assign in_xfer     = i_in_valid && !o_in_stall;

    assign o_out_byte = r_slot[0].data;
    assign o_is_sync  = r_slot[0].is_sync;
    assign o_last     = (r_count == 2'd1);

    always_comb begin
        n_slot  = r_slot;
        n_count = r_count;
        if (in_xfer) begin
            n_slot  = batch.slot;
            n_count = batch.count;
        end else if (out_xfer) begin
            n_slot[0] = r_slot[1];
            n_slot[1] = r_slot[2];
            n_count   = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= '0;
            r_count       <= 2'd0;
            r_sync_byte   <= SYNC_BYTE_RESET;
            r_sync_period <= SYNC_PERIOD_RESET;
        end else begin
            r_count <= n_count;
            if (in_xfer) begin
                r_state <= n_state;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SYNC_BYTE:   r_sync_byte   <= i_cfg_data[7:0];
                    CFG_SYNC_PERIOD: r_sync_period <= i_cfg_data;
                    default:         r_sync_period <= r_sync_period;
                endcase
            end
        end
    end

    // payload slots carry no reset
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

endmodule

// ===== sim/sample_byte_packer_sync_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_byte_packer_sync_tb - self-checking bench for the sample byte packer
// Feeds encode and start commands through the input channel. A packing model
// in the bench predicts every byte, its sync flag and its last flag. The
// output channel is checked in order. Both sides idle and stall at random,
// with one long receiver hold-off, across several sync byte and period
// settings.
// ----------------------------------------------------------------------------
module sample_byte_packer_sync_tb;
    import sbp_pkg::*;

    localparam int SAMPLE_BITS  = 12;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;
    localparam int SETTLE_LIMIT = 4000;

    // one input transfer: command plus sample
    typedef struct packed {
        logic                   cmd;
        logic [SAMPLE_BITS-1:0] smp;
    } t_sample_req;

    // one byte on the link as the packer should send it
    typedef struct packed {
        logic [7:0] value;
        logic       is_sync;
        logic       last;
    } t_link_byte;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_cfg_we       = 1'b0;
    logic                   i_cfg_index    = CFG_SYNC_BYTE;
    logic [15:0]            i_cfg_data     = '0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_stall;
    logic                   i_command      = CMD_ENCODE;
    logic [SAMPLE_BITS-1:0] i_sample_value = '0;
    logic                   o_out_valid;
    logic                   i_out_stall    = 1'b0;
    logic [7:0]             o_out_byte;
    logic                   o_is_sync;
    logic                   o_last;

    sample_byte_packer_sync #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_sample_value (i_sample_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_is_sync      (o_is_sync),
        .o_last         (o_last)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_sample_req pending_items[$];    // filled by the sequence, drained by the driver
    t_link_byte  link_bytes_due[$];   // predicted bytes, oldest first

    // shadow of the register file, written only while the packer is idle
    logic [7:0]  cfg_sync_byte   = SYNC_BYTE_RESET;
    logic [15:0] cfg_sync_period = SYNC_PERIOD_RESET;

    // packing state of the model
    logic [CARRY_W-1:0] pk_carry      = '0;
    logic [COUNT_W-1:0] pk_count      = '0;
    logic [BSS_W-1:0]   pk_since_sync = '0;

    int cycle_count   = 0;
    int err_count     = 0;
    int items_sent    = 0;
    int starts_sent   = 0;
    int bytes_checked = 0;
    int syncs_seen    = 0;
    int escapes_made  = 0;
    int cfg_writes    = 0;

    // sender burst shaping
    int burst_left = 1;
    int gap_left   = 0;

    // receiver stall shaping
    int stall_mode = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    // ------------------------------------------------------------------
    // Clock, reset, cycle limit
    // ------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still due",
                     cycle_count, link_bytes_due.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Mismatch report: one line, capped so a broken run stays readable
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        if (err_count < 40)
            $display("MISMATCH cycle %0d: %s got 0x%0h want 0x%0h",
                     cycle_count, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Packing model. Runs at each accepted input transfer and queues the
    // bytes that transfer should cause.
    // ------------------------------------------------------------------
    task automatic pack_sample(logic cmd, logic [SAMPLE_BITS-1:0] smp);
        t_link_byte  made[3];
        int          n;
        int          k;
        int          total;
        int          lsb;
        int          period;
        logic [18:0] acc;
        logic [7:0]  b;
        bit          first;

        n = 0;
        if (cmd == CMD_START) begin
            // start: marker only, carry and byte count are thrown away
            made[0]       = '{value: cfg_sync_byte, is_sync: 1'b1, last: 1'b0};
            n             = 1;
            pk_carry      = '0;
            pk_count      = '0;
            pk_since_sync = '0;
        end else begin
            k     = int'(pk_count);
            acc   = ({12'd0, pk_carry & ((7'd1 << k) - 7'd1)} << SAMPLE_BITS)
                  | {7'd0, smp};
            total = k + SAMPLE_BITS;
            first = 1'b1;
            while (total >= 8) begin
                b = 8'(acc >> (total - 8));
                // look-alike of the marker: flip the first bit that came from
                // this sample (bit 7-k when the byte opens with k carried bits)
                if (b == cfg_sync_byte) begin
                    lsb = (first && k != 0) ? k : FULL_BYTE_LSB;
                    b   = b ^ (TOP_BIT >> lsb);
                    escapes_made++;
                end
                made[n] = '{value: b, is_sync: 1'b0, last: 1'b0};
                n++;
                if (pk_since_sync != 16'hFFFF)
                    pk_since_sync = pk_since_sync + 16'd1;
                total -= 8;
                first = 1'b0;
            end
            pk_count = COUNT_W'(total);
            pk_carry = CARRY_W'(acc & ((19'd1 << total) - 19'd1));

            // marker check only on a byte boundary; period 0 acts as 1
            if (total == 0) begin
                period = (cfg_sync_period == 16'd0) ? 1 : int'(cfg_sync_period);
                if (int'(pk_since_sync) + 1 >= period) begin
                    made[n] = '{value: cfg_sync_byte, is_sync: 1'b1, last: 1'b0};
                    n++;
                    pk_since_sync = '0;
                end
            end
        end

        if (n > 0)
            made[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            link_bytes_due.push_back(made[i]);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents items in bursts with random gaps. A new item is put
    // up only when the last one transferred or nothing was offered.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_input
        t_sample_req req;

        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                req            = pending_items.pop_front();
                i_command      <= req.cmd;
                i_sample_value <= req.smp;
                i_in_valid     <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    // a quarter of bursts run straight into the next one
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: one of four patterns, redrawn at random. Once a large
    // batch is waiting, the receiver holds off once, so the packer's
    // result queue fills and its input stalls while items keep coming.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (cycle_count % 48 == 0)
                stall_mode <= $urandom_range(0, 3);

            if (!hold_done && pending_items.size() >= 100) begin
                hold_left   <= 300;
                hold_done   <= 1'b1;
                i_out_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left   <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 2) == 0);
                    2: i_out_stall <= ((cycle_count % 4) >= 2);
                    default: i_out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks output transfers against the oldest prediction, then
    // runs the model on any input transfer at the same edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_link
        t_link_byte want;

        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (link_bytes_due.size() == 0) begin
                    report_mismatch("byte with nothing due", o_out_byte, 0);
                end else begin
                    want = link_bytes_due.pop_front();
                    if (o_out_byte !== want.value)
                        report_mismatch("out_byte", o_out_byte, want.value);
                    if (o_is_sync !== want.is_sync)
                        report_mismatch("is_sync", o_is_sync, want.is_sync);
                    if (o_last !== want.last)
                        report_mismatch("last", o_last, want.last);
                    bytes_checked++;
                    if (want.is_sync)
                        syncs_seen++;
                end
            end

            if (i_in_valid && !o_in_stall) begin
                pack_sample(i_command, i_sample_value);
                items_sent++;
                if (i_command == CMD_START)
                    starts_sent++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------
    task automatic add_item(logic cmd, logic [SAMPLE_BITS-1:0] smp);
        pending_items.push_back('{cmd: cmd, smp: smp});
    endtask

    // Mostly samples, a few starts, and a share built to hit the marker
    // value in every byte position.
    task automatic add_random(int count);
        logic [7:0]             s;
        logic [SAMPLE_BITS-1:0] smp;
        int                     pick;

        for (int i = 0; i < count; i++) begin
            s    = cfg_sync_byte;
            pick = $urandom_range(0, 99);
            smp  = SAMPLE_BITS'($urandom);
            if (pick < 5) begin
                add_item(CMD_START, smp);
            end else begin
                if (pick < 30) begin
                    case ($urandom_range(0, 2))
                        0: smp = {s, 4'($urandom)};      // whole byte, no carry
                        1: smp = {s[3:0], s};            // carried half plus low byte
                        default: smp = {4'($urandom), s};
                    endcase
                end
                add_item(CMD_ENCODE, smp);
            end
        end
    endtask

    // Sender finished and every predicted byte delivered; spare cycles
    // follow, since the packer answers in the cycle after a transfer.
    task automatic wait_idle();
        while (pending_items.size() != 0 || i_in_valid || link_bytes_due.size() != 0)
            @(negedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_SYNC_BYTE)
            cfg_sync_byte = val[7:0];
        else
            cfg_sync_period = val;
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int settle;

        @(posedge i_rst_n);
        @(posedge i_clk);

        // Reset settings (marker 0xFF, period 64). Directed: marker at
        // start, all-ones samples that need escaping in both byte positions,
        // a start on a byte boundary, back-to-back starts.
        add_item(CMD_START,  12'h000);
        add_item(CMD_ENCODE, 12'hFFF);
        add_item(CMD_ENCODE, 12'hFFF);
        add_item(CMD_ENCODE, 12'h000);
        add_item(CMD_ENCODE, 12'h800);
        add_item(CMD_ENCODE, 12'h001);
        add_item(CMD_ENCODE, 12'hFFF);
        add_item(CMD_START,  12'hFFF);
        add_item(CMD_START,  12'h5A5);
        add_item(CMD_ENCODE, 12'hFF0);
        add_item(CMD_ENCODE, 12'hFFF);
        add_random(30);
        wait_idle();

        // Marker 0x00 with junk in the unused upper data bits, period 0:
        // a marker after every boundary, zero samples need escaping.
        write_reg(CFG_SYNC_BYTE, 16'hC300);
        write_reg(CFG_SYNC_PERIOD, 16'd0);
        add_item(CMD_START,  12'hFFF);
        add_item(CMD_ENCODE, 12'h000);
        add_item(CMD_ENCODE, 12'h000);
        add_item(CMD_ENCODE, 12'h00F);
        add_item(CMD_ENCODE, 12'h0F0);
        add_random(40);
        wait_idle();

        // Marker 0xA5, period 1.
        write_reg(CFG_SYNC_BYTE, 16'h00A5);
        write_reg(CFG_SYNC_PERIOD, 16'd1);
        add_item(CMD_START,  12'h000);
        add_item(CMD_ENCODE, 12'hA5A);
        add_item(CMD_ENCODE, 12'h5A5);
        add_item(CMD_ENCODE, 12'hA5A);
        add_item(CMD_ENCODE, 12'h5A5);
        add_random(30);
        wait_idle();

        // Random marker, period 3; the big batch triggers the long hold-off.
        write_reg(CFG_SYNC_BYTE, 16'($urandom));
        write_reg(CFG_SYNC_PERIOD, 16'd3);
        add_random(120);
        wait_idle();

        // Largest period: no periodic markers, only starts send one.
        write_reg(CFG_SYNC_BYTE, 16'h00FF);
        write_reg(CFG_SYNC_PERIOD, 16'hFFFF);
        add_random(50);
        wait_idle();

        // Random marker and short random period.
        write_reg(CFG_SYNC_BYTE, 16'($urandom));
        write_reg(CFG_SYNC_PERIOD, 16'($urandom_range(2, 20)));
        add_random(50);

        // sender done, then let the link settle with a bound
        while (pending_items.size() != 0 || i_in_valid)
            @(negedge i_clk);
        settle = 0;
        while (link_bytes_due.size() != 0 && settle < SETTLE_LIMIT) begin
            @(negedge i_clk);
            settle++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (link_bytes_due.size() != 0)
            report_mismatch("bytes never delivered", 0, link_bytes_due.size());

        $display("covered %0d input transfers (%0d starts), %0d bytes checked",
                 items_sent, starts_sent, bytes_checked);
        $display("%0d sync markers, %0d escaped bytes, %0d register writes",
                 syncs_seen, escapes_made, cfg_writes);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
src/sbp_pkg.sv
src/sbp_pack.sv
src/sample_byte_packer_sync.sv
sim/sample_byte_packer_sync_tb.sv
